### rtl/core/hds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants of the heat diffusion stencil step
// Field widths, register indexes, arithmetic widths and the result tag.
// ----------------------------------------------------------------------------
package hds_pkg;

  // field widths
  localparam int VALUE_W     = 32;   // signed Q16.16 temperature
  localparam int COEF_W      = 16;   // unsigned Q0.16 coefficient
  localparam int OUT_IDX_W   = 10;   // out_row / out_col
  localparam int SIZE_W      = 11;   // grid_rows / grid_cols
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // size defaults
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MIN_SIZE     = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_X    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_Y    = 2'd3;

  // datapath widths: second difference, product, rounded sum
  localparam int DIFF_W = VALUE_W + 2;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  // where the result goes and which border copies follow it
  typedef struct packed {
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 top;
    logic                 bottom;
    logic                 left;
    logic                 right;
    logic                 grid_last;
  } hds_tag_t;

endpackage
`default_nettype wire

### rtl/core/heat_diffusion_stencil_step.sv
`timescale 1ns / 1ps
`default_nettype none
// A cell's first result word passes stage 2, the arithmetic stages and the output register.
// Throughput: one cell a cycle unless stalled; a cell next to the border owes one output
//   word per copy (up to 4); the single output register sends one word a cycle on out_ready.
// Reset (rst, synchronous): counters, valids and registers to defaults (3 x 3 grid, zero
//   coefficients). Line memory is not cleared; it is only read where written this pass.
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step: explicit 2D heat equation, five-point stencil
// Cells stream in raster order; a line memory holds the two rows above.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step #(
  parameter int MAX_COLS = hds_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hds_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration
  input  wire logic                                   cfg_write,
  input  wire logic        [hds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [hds_pkg::CFG_DATA_W-1:0]  cfg_data,
  // cell stream
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [hds_pkg::VALUE_W-1:0]     cell_value,
  // result stream
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed      [hds_pkg::VALUE_W-1:0]     new_value,
  output logic             [hds_pkg::OUT_IDX_W-1:0]   out_row,
  output logic             [hds_pkg::OUT_IDX_W-1:0]   out_col,
  output logic                                        last_of_item,
  output logic                                        last_of_grid
);

  localparam int VW    = hds_pkg::VALUE_W;
  localparam int SZW   = hds_pkg::SIZE_W;
  localparam int IW    = hds_pkg::OUT_IDX_W;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);

  // --------------------------------------------------------------------------
  // Configuration. Sizes are clamped on write and kept as last index.
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]          last_row, last_row_next;
  logic [COL_W-1:0]          last_col, last_col_next;
  logic [hds_pkg::COEF_W-1:0] coef_x, coef_y;
  logic [SZW-1:0]            size_wr;
  logic                      size_write;

  assign size_wr    = cfg_data[SZW-1:0];
  assign size_write = cfg_write &&
                      (cfg_index == hds_pkg::REG_GRID_ROWS ||
                       cfg_index == hds_pkg::REG_GRID_COLS);

  always_comb begin
    priority if (size_wr < SZW'(hds_pkg::MIN_SIZE)) begin
      last_row_next = ROW_W'(hds_pkg::MIN_SIZE - 1);
    end else if (32'(size_wr) > MAX_ROWS) begin
      last_row_next = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row_next = ROW_W'(size_wr - SZW'(1));
    end
    priority if (size_wr < SZW'(hds_pkg::MIN_SIZE)) begin
      last_col_next = COL_W'(hds_pkg::MIN_SIZE - 1);
    end else if (32'(size_wr) > MAX_COLS) begin
      last_col_next = COL_W'(MAX_COLS - 1);
    end else begin
      last_col_next = COL_W'(size_wr - SZW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row <= ROW_W'(hds_pkg::MIN_SIZE - 1);
      last_col <= COL_W'(hds_pkg::MIN_SIZE - 1);
      coef_x   <= '0;
      coef_y   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hds_pkg::REG_GRID_ROWS: last_row <= last_row_next;
        hds_pkg::REG_GRID_COLS: last_col <= last_col_next;
        hds_pkg::REG_COEF_X:    coef_x   <= cfg_data[hds_pkg::COEF_W-1:0];
        hds_pkg::REG_COEF_Y:    coef_y   <= cfg_data[hds_pkg::COEF_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Everything moves together on adv; the pipeline stalls
  // only when the arithmetic output holds a result the sequencer cannot take.
  // --------------------------------------------------------------------------
  logic adv, accept, take;
  logic alu_valid;

  assign adv      = take || !alu_valid;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // raster position of the incoming word
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (col == last_col) begin
        col <= '0;
        row <= (row == last_row) ? ROW_W'(0) : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // cell (row, col) completes the interior cell (row-1, col-1)
  hds_pkg::hds_tag_t tag_in;

  always_comb begin
    tag_in.row       = IW'(row - ROW_W'(1));
    tag_in.col       = IW'(col - COL_W'(1));
    tag_in.top       = row == ROW_W'(2);
    tag_in.bottom    = row == last_row;
    tag_in.left      = col == COL_W'(2);
    tag_in.right     = col == last_col;
    tag_in.grid_last = (row == last_row) && (col == last_col);
  end

  // --------------------------------------------------------------------------
  // Line memory. Each entry k packs {two rows above, one row above}, so one
  // read at the incoming column serves both rows; a one-row shift is the
  // write-back of {old one-above, new cell}.
  // --------------------------------------------------------------------------
  logic                   ram_we;
  logic [COL_W-1:0]       ram_waddr;
  logic [2*VW-1:0]        ram_wdata;
  logic [2*VW-1:0]        rd_word;
  logic signed [VW-1:0]   rd_one, rd_two;

  hds_ram #(
    .WIDTH (2 * VW),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (rd_word)
  );

  assign rd_one = rd_word[VW-1:0];
  assign rd_two = rd_word[2*VW-1:VW];

  // --------------------------------------------------------------------------
  // Stage 2: the word whose memory read has returned.
  // --------------------------------------------------------------------------
  logic                 s2_valid;
  logic signed [VW-1:0] s2_cell;
  logic [COL_W-1:0]     s2_col;
  logic                 s2_produce, s2_rowend;
  hds_pkg::hds_tag_t    s2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_cell    <= cell_value;
      s2_col     <= col;
      s2_produce <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      s2_rowend  <= col == last_col;
      s2_tag     <= tag_in;
    end
  end

  // History along the row: one-above at columns c-1 and c-2, two-above at
  // c-1, and the previous cell. Reading at c is safe: writes trail at c-1.
  logic signed [VW-1:0] h_one1, h_one2, h_two1, h_prev;
  logic                 s2_go;

  assign s2_go = s2_valid && adv;

  always_ff @(posedge clk) begin
    if (s2_go) begin
      h_one2 <= h_one1;
      h_one1 <= rd_one;
      h_two1 <= rd_two;
      h_prev <= s2_cell;
    end
  end

  // At the row end the last column is shifted too; that write goes out in
  // the following cycle, when the next word (column 0) writes nothing.
  logic             pend_valid;
  logic [COL_W-1:0] pend_addr;
  logic [2*VW-1:0]  pend_data;
  logic             s2_wr;

  assign s2_wr = s2_go && (s2_col != COL_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= s2_go && s2_rowend;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_rowend) begin
      pend_addr <= s2_col;
      pend_data <= {rd_one, s2_cell};
    end
  end

  always_comb begin
    priority if (pend_valid) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr;
      ram_wdata = pend_data;
    end else begin
      ram_we    = s2_wr;
      ram_waddr = s2_col - COL_W'(1);
      ram_wdata = {h_one1, h_prev};
    end
  end

  // --------------------------------------------------------------------------
  // Arithmetic and result sequencing
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] alu_value;
  hds_pkg::hds_tag_t    alu_tag;

  hds_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s2_valid && s2_produce),
    .west      (h_one2),
    .centre    (h_one1),
    .east      (rd_one),
    .north     (h_two1),
    .south     (h_prev),
    .coef_x    (coef_x),
    .coef_y    (coef_y),
    .in_tag    (s2_tag),
    .out_valid (alu_valid),
    .out_value (alu_value),
    .out_tag   (alu_tag)
  );

  hds_expand u_expand (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (alu_valid),
    .in_value     (alu_value),
    .in_tag       (alu_tag),
    .last_row     (IW'(last_row)),
    .last_col     (IW'(last_col)),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_value    (new_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_item (last_of_item),
    .last_of_grid (last_of_grid)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && s2_wr))
    else $error("row-end write clashes with a stage 2 write");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (row <= last_row) && (col <= last_col))
    else $error("raster position beyond grid size");

  a_pend_last_col: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (pend_addr == last_col))
    else $error("deferred write not at the last column");

  a_grid_end_closes_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_grid) |-> last_of_item)
    else $error("grid end flagged on a word that is not last of its cell");

endmodule
`default_nettype wire

### rtl/core/hds_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hds_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hds_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // holds its word while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/hds_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hds_alu: five-point stencil arithmetic
// Four stages: differences, products, rounded sum, shift and saturate.
// ----------------------------------------------------------------------------
module hds_alu (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                in_valid,
  input  wire logic signed [hds_pkg::VALUE_W-1:0]  west,
  input  wire logic signed [hds_pkg::VALUE_W-1:0]  centre,
  input  wire logic signed [hds_pkg::VALUE_W-1:0]  east,
  input  wire logic signed [hds_pkg::VALUE_W-1:0]  north,
  input  wire logic signed [hds_pkg::VALUE_W-1:0]  south,
  input  wire logic        [hds_pkg::COEF_W-1:0]   coef_x,
  input  wire logic        [hds_pkg::COEF_W-1:0]   coef_y,
  input  wire hds_pkg::hds_tag_t                   in_tag,
  output logic                                     out_valid,
  output logic signed      [hds_pkg::VALUE_W-1:0]  out_value,
  output hds_pkg::hds_tag_t                        out_tag
);

  localparam int VW = hds_pkg::VALUE_W;
  localparam int CW = hds_pkg::COEF_W;
  localparam int DW = hds_pkg::DIFF_W;
  localparam int PW = hds_pkg::PROD_W;
  localparam int SW = hds_pkg::SUM_W;
  localparam int HW = SW - CW;   // width after the shift
  localparam logic signed [SW-1:0] HALF = SW'(1) << (CW - 1);

  logic                 v1, v2, v3;
  logic signed [DW-1:0] dx, dy;
  logic signed [VW-1:0] c1, c2;
  logic signed [PW-1:0] px, py;
  logic signed [SW-1:0] sum;
  hds_pkg::hds_tag_t    t1, t2, t3;
  logic signed [HW-1:0] shifted;
  logic                 ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  assign shifted = sum[SW-1:CW];
  // overflow when the bits above the result's sign disagree with it
  assign ovf = (shifted[HW-1:VW-1] != {(HW-VW+1){1'b0}}) &&
               (shifted[HW-1:VW-1] != {(HW-VW+1){1'b1}});

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= DW'(west) + DW'(east) - (DW'(centre) <<< 1);
      dy  <= DW'(north) + DW'(south) - (DW'(centre) <<< 1);
      c1  <= centre;
      t1  <= in_tag;

      px  <= $signed({1'b0, coef_x}) * dx;
      py  <= $signed({1'b0, coef_y}) * dy;
      c2  <= c1;
      t2  <= t1;

      sum <= (SW'(c2) <<< CW) + SW'(px) + SW'(py) + HALF;
      t3  <= t2;

      if (ovf) begin
        out_value <= {shifted[HW-1], {(VW-1){~shifted[HW-1]}}};
      end else begin
        out_value <= shifted[VW-1:0];
      end
      out_tag <= t3;
    end
  end

endmodule
`default_nettype wire

### rtl/core/hds_expand.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hds_expand: result sequencer
// Emits each result and its reflected border copies, a word a cycle on ready.
// ----------------------------------------------------------------------------
module hds_expand (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire logic signed [hds_pkg::VALUE_W-1:0]   in_value,
  input  wire hds_pkg::hds_tag_t                    in_tag,
  input  wire logic        [hds_pkg::OUT_IDX_W-1:0] last_row,
  input  wire logic        [hds_pkg::OUT_IDX_W-1:0] last_col,
  output logic                                      take,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [hds_pkg::VALUE_W-1:0]   new_value,
  output logic             [hds_pkg::OUT_IDX_W-1:0] out_row,
  output logic             [hds_pkg::OUT_IDX_W-1:0] out_col,
  output logic                                      last_of_item,
  output logic                                      last_of_grid
);

  localparam int IW = hds_pkg::OUT_IDX_W;

  // words still owed: cell, top, bottom, left, right (lowest goes first)
  logic [4:0]        owed;
  logic              single;
  hds_pkg::hds_tag_t tag;

  assign single    = (owed & (owed - 5'd1)) == 5'd0;
  assign out_valid = owed != 5'd0;
  assign take      = !out_valid || (out_ready && single);

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= 5'd0;
    end else if (take) begin
      owed <= in_valid ? {in_tag.right, in_tag.left, in_tag.bottom, in_tag.top, 1'b1}
                       : 5'd0;
    end else if (out_ready) begin
      owed <= owed & (owed - 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      new_value <= in_value;
      tag       <= in_tag;
    end
  end

  always_comb begin
    priority if (owed[0]) begin
      out_row = tag.row;
      out_col = tag.col;
    end else if (owed[1]) begin
      out_row = '0;
      out_col = tag.col;
    end else if (owed[2]) begin
      out_row = last_row;
      out_col = tag.col;
    end else if (owed[3]) begin
      out_row = tag.row;
      out_col = IW'(0);
    end else begin
      out_row = tag.row;
      out_col = last_col;
    end
  end

  assign last_of_item = single;
  assign last_of_grid = single && tag.grid_last;

endmodule
`default_nettype wire
